FILE: design/smrp_pkg.sv
// ----------------------------------------------------------------------------
// smrp_pkg
// Shared constants, token codes and types for the SGR mouse report parser.
// ----------------------------------------------------------------------------
package smrp_pkg;

  localparam int MAX_SEQ_LEN_DEF = 64;
  localparam int NUM_WIDTH_DEF   = 16;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBRK  = 8'h5B;
  localparam logic [7:0] BYTE_LT    = 8'h3C;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_FIN_P = 8'h4D;
  localparam logic [7:0] BYTE_FIN_R = 8'h6D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam int CODE_WHEEL  = 64;
  localparam int CODE_MOTION = 32;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_OTHER = 3'd0;
  localparam kind_t KIND_ESC   = 3'd1;
  localparam kind_t KIND_LBRK  = 3'd2;
  localparam kind_t KIND_LT    = 3'd3;
  localparam kind_t KIND_DIGIT = 3'd4;
  localparam kind_t KIND_SEMI  = 3'd5;
  localparam kind_t KIND_FIN_P = 3'd6;
  localparam kind_t KIND_FIN_R = 3'd7;

  localparam logic signed [1:0] WHEEL_NONE = 2'sb00;
  localparam logic signed [1:0] WHEEL_UP   = 2'sb01;
  localparam logic signed [1:0] WHEEL_DOWN = 2'sb11;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } tok_t;

endpackage

FILE: design/sgr_mouse_report_parser_unit.sv
// ----------------------------------------------------------------------------
// sgr_mouse_report_parser_unit
// Decodes SGR mouse reports (ESC [ < code ; col ; row M/m) from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_byte carries one terminal byte per
//   transfer. Output channel out_valid/out_ready carries one result per
//   completed report: held buttons, zero-based column and row, wheel step
//   and press flag. Bytes that do not complete a report give no result.
//   Throughput is one byte per cycle while in_ready is high. A byte is
//   classified on entry and held in a two-entry token queue; the report
//   engine takes one token a cycle unless a new result would overwrite
//   one not yet taken. A final byte is written to the queue, then its
//   result to the output register that drives out_valid. While the
//   receiver stalls, the engine keeps taking bytes until the next final
//   byte that completes a report, which waits at the head of the queue;
//   one more byte fits behind it before in_ready drops. Reset clears the
//   prefix state, the held-button mask, the queue and the output valid.
// ----------------------------------------------------------------------------
module sgr_mouse_report_parser_unit
  import smrp_pkg::*;
#(
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF,
  parameter int NUM_WIDTH   = NUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_buttons,
  output logic [15:0]       out_pointer_x,
  output logic [15:0]       out_pointer_y,
  output logic signed [1:0] out_wheel,
  output logic              out_pressed
);

  tok_t in_tok;
  tok_t q_tok;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_ready = !q_full;

  smrp_front u_front (
    .in_byte (in_byte),
    .tok     (in_tok)
  );

  smrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_valid && in_ready),
    .wr_tok   (in_tok),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_tok   (q_tok)
  );

  smrp_back #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN),
    .NUM_WIDTH   (NUM_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (q_valid),
    .tok           (q_tok),
    .tok_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_buttons   (out_buttons),
    .out_pointer_x (out_pointer_x),
    .out_pointer_y (out_pointer_y),
    .out_wheel     (out_wheel),
    .out_pressed   (out_pressed)
  );

endmodule

FILE: design/smrp_front.sv
// ----------------------------------------------------------------------------
// smrp_front
// Byte classifier: maps a raw stream byte to a token kind and digit value.
// ----------------------------------------------------------------------------
module smrp_front
  import smrp_pkg::*;
(
  input  logic [7:0] in_byte,
  output tok_t       tok
);

  always_comb begin
    tok.digit = 4'(in_byte - BYTE_ZERO);
    case (in_byte)
      BYTE_ESC:   tok.kind = KIND_ESC;
      BYTE_LBRK:  tok.kind = KIND_LBRK;
      BYTE_LT:    tok.kind = KIND_LT;
      BYTE_SEMI:  tok.kind = KIND_SEMI;
      BYTE_FIN_P: tok.kind = KIND_FIN_P;
      BYTE_FIN_R: tok.kind = KIND_FIN_R;
      default: begin
        if (in_byte >= BYTE_ZERO && in_byte <= BYTE_NINE) begin
          tok.kind = KIND_DIGIT;
        end else begin
          tok.kind = KIND_OTHER;
        end
      end
    endcase
  end

endmodule

FILE: design/smrp_queue.sv
// ----------------------------------------------------------------------------
// smrp_queue
// Two-entry token queue between the classifier and the report engine.
// ----------------------------------------------------------------------------
module smrp_queue
  import smrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  tok_t wr_tok,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output tok_t rd_tok
);

  tok_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (rd_en) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

endmodule

FILE: design/smrp_back.sv
// ----------------------------------------------------------------------------
// smrp_back
// Report engine: tracks the escape prefix, accumulates decimal fields,
// updates the held-button mask and registers one result per report.
// ----------------------------------------------------------------------------
module smrp_back
  import smrp_pkg::*;
#(
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF,
  parameter int NUM_WIDTH   = NUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  tok_t              tok,
  output logic              tok_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_buttons,
  output logic [15:0]       out_pointer_x,
  output logic [15:0]       out_pointer_y,
  output logic signed [1:0] out_wheel,
  output logic              out_pressed
);

  localparam int LW = $clog2(MAX_SEQ_LEN + 1);
  localparam int XW = (NUM_WIDTH > 16) ? NUM_WIDTH : 17;
  localparam int AW = NUM_WIDTH + 4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LBRK = 2'd1;
  localparam logic [1:0] PH_LT   = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           fcnt_r, fcnt_nxt;
  logic [LW-1:0]        seq_r, seq_nxt;
  logic [NUM_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUM_WIDTH-1:0] f1_r, f1_nxt;
  logic [NUM_WIDTH-1:0] f2_r, f2_nxt;
  logic [NUM_WIDTH-1:0] f3_r, f3_nxt;
  logic [2:0]           mask_r, mask_nxt;
  logic                 emit;

  logic                 ov_r;
  logic [2:0]           ob_r;
  logic [15:0]          ox_r, oy_r;
  logic signed [1:0]    ow_r, ow_nxt;
  logic                 op_r;

  logic [LW-1:0]        pos;
  logic [AW-1:0]        acc_wide;
  logic [XW-1:0]        code_x, f2_x, f3_x;
  logic [NUM_WIDTH-1:0] f3_eff;
  logic [1:0]           sel;
  logic [2:0]           bit_sel;
  logic                 press;
  logic                 go_idle;

  assign tok_pop  = tok_valid && (!emit || !ov_r || out_ready);
  assign pos      = seq_r + LW'(1);
  assign acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + AW'(tok.digit);
  assign press    = (tok.kind == KIND_FIN_P);
  assign f3_eff   = (fcnt_r == 2'd2) ? acc_r : f3_r;
  assign code_x   = XW'(f1_r);
  assign f2_x     = XW'(f2_r);
  assign f3_x     = XW'(f3_eff);
  assign sel      = code_x[1:0];
  assign bit_sel  = (sel == 2'd3) ? 3'b000 : (3'b001 << sel);

  always_comb begin
    phase_nxt = phase_r;
    fcnt_nxt  = fcnt_r;
    seq_nxt   = seq_r;
    acc_nxt   = acc_r;
    f1_nxt    = f1_r;
    f2_nxt    = f2_r;
    f3_nxt    = f3_r;
    mask_nxt  = mask_r;
    ow_nxt    = WHEEL_NONE;
    emit      = 1'b0;
    go_idle   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (tok.kind == KIND_ESC) begin
          phase_nxt = PH_LBRK;
          seq_nxt   = LW'(1);
          fcnt_nxt  = 2'd0;
          acc_nxt   = '0;
        end
      end
      PH_LBRK, PH_LT: begin
        if ((tok.kind != ((phase_r == PH_LBRK) ? KIND_LBRK : KIND_LT)) ||
            (pos >= LW'(MAX_SEQ_LEN))) begin
          go_idle = 1'b1;
        end else begin
          phase_nxt = phase_r + 2'd1;
          seq_nxt   = pos;
        end
      end
      PH_BODY: begin
        if (tok.kind == KIND_FIN_P || tok.kind == KIND_FIN_R) begin
          go_idle = 1'b1;
          if (pos <= LW'(MAX_SEQ_LEN) && fcnt_r >= 2'd2) begin
            emit   = 1'b1;
            f3_nxt = f3_eff;
            if (code_x >= XW'(CODE_WHEEL)) begin
              mask_nxt = 3'b000;
              if (code_x >= XW'(17'h10000) || code_x[0]) begin
                ow_nxt = WHEEL_DOWN;
              end else begin
                ow_nxt = WHEEL_UP;
              end
            end else if (code_x >= XW'(CODE_MOTION)) begin
              mask_nxt = {1'b0, sel};
            end else if (press) begin
              mask_nxt = mask_r | bit_sel;
            end else begin
              mask_nxt = mask_r & ~bit_sel;
            end
          end
        end else if (pos >= LW'(MAX_SEQ_LEN)) begin
          go_idle = 1'b1;
        end else if (tok.kind == KIND_DIGIT) begin
          seq_nxt = pos;
          if (acc_wide[AW-1:NUM_WIDTH] != 4'd0) begin
            acc_nxt = '1;
          end else begin
            acc_nxt = acc_wide[NUM_WIDTH-1:0];
          end
        end else if (tok.kind == KIND_SEMI) begin
          seq_nxt = pos;
          case (fcnt_r)
            2'd0:    f1_nxt = acc_r;
            2'd1:    f2_nxt = acc_r;
            2'd2:    f3_nxt = acc_r;
            default: f3_nxt = f3_r;
          endcase
          if (fcnt_r != 2'd3) begin
            fcnt_nxt = fcnt_r + 2'd1;
          end
          acc_nxt = '0;
        end else begin
          go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase
    if (go_idle) begin
      phase_nxt = PH_IDLE;
      fcnt_nxt  = 2'd0;
      seq_nxt   = '0;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fcnt_r  <= 2'd0;
      seq_r   <= '0;
      acc_r   <= '0;
      mask_r  <= 3'b000;
      ov_r    <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase_r <= phase_nxt;
        fcnt_r  <= fcnt_nxt;
        seq_r   <= seq_nxt;
        acc_r   <= acc_nxt;
        mask_r  <= mask_nxt;
      end
      if (tok_pop && emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
    end
    if (tok_pop && emit) begin
      ob_r <= mask_nxt;
      ox_r <= f2_x[15:0] - 16'd1;
      oy_r <= f3_x[15:0] - 16'd1;
      ow_r <= ow_nxt;
      op_r <= press;
    end
  end

  assign out_valid     = ov_r;
  assign out_buttons   = ob_r;
  assign out_pointer_x = ox_r;
  assign out_pointer_y = oy_r;
  assign out_wheel     = ow_r;
  assign out_pressed   = op_r;

endmodule

FILE: design/smrp_checker.sv
// ----------------------------------------------------------------------------
// smrp_checker
// Port-level checks for the SGR mouse report parser, bound to the top level.
// ----------------------------------------------------------------------------
module smrp_checker
  import smrp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_buttons,
  input logic [15:0]       out_pointer_x,
  input logic [15:0]       out_pointer_y,
  input logic signed [1:0] out_wheel,
  input logic              out_pressed
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_buttons) &&
      $stable(out_pointer_x) && $stable(out_pointer_y) &&
      $stable(out_wheel) && $stable(out_pressed))
    else $error("stalled result changed");

  a_wheel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wheel != 2'sb10)
    else $error("invalid wheel code");

  a_wheel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wheel != WHEEL_NONE |-> out_buttons == 3'b000)
    else $error("wheel event with buttons held");

  a_stall_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled without a waiting result");

endmodule

bind sgr_mouse_report_parser_unit smrp_checker u_smrp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_buttons   (out_buttons),
  .out_pointer_x (out_pointer_x),
  .out_pointer_y (out_pointer_y),
  .out_wheel     (out_wheel),
  .out_pressed   (out_pressed)
);
